[hw/rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, request codes and the command/status bundles of the edge store.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int FILL_W    = $clog2(MAX_EDGES + 1);

  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic               append;
    logic               clear;
    logic [CNT_W-1:0]   from_num;
    logic [CNT_W-1:0]   to_num;
    logic [CNT_W-1:0]   n;
    logic [EADDR_W-1:0] rd_addr;
  } es_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              drop;
    logic [NODE_W-1:0] rd_src;
    logic [NODE_W-1:0] rd_tgt;
  } es_stat_t;

endpackage

[hw/rtl/scc_if.sv]
// ----------------------------------------------------------------------------
// scc_if
// Valid/ready channel interfaces for edge requests and per-node results.
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [scc_pkg::CNT_W-1:0] edge_from;
  logic [scc_pkg::CNT_W-1:0] edge_to;
  modport source(output valid, req_type, edge_from, edge_to, input ready);
  modport sink(input valid, req_type, edge_from, edge_to, output ready);
endinterface

interface scc_out_if;
  logic                     valid;
  logic                     ready;
  logic [scc_pkg::CNT_W-1:0] node_number;
  logic [scc_pkg::CNT_W-1:0] component_label;
  logic [scc_pkg::CNT_W-1:0] component_total;
  logic                     dropped_edges;
  logic                     last_node;
  modport source(output valid, node_number, component_label, component_total,
                 dropped_edges, last_node, input ready);
  modport sink(input valid, node_number, component_label, component_total,
               dropped_edges, last_node, output ready);
endinterface

[hw/rtl/scc_edge_store.sv]
// ----------------------------------------------------------------------------
// scc_edge_store
// Edge memory with fill count and drop flag; one registered read port.
// ----------------------------------------------------------------------------
module scc_edge_store (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_pkg::es_cmd_t  cmd,
  output scc_pkg::es_stat_t stat
);
  import scc_pkg::*;

  logic [2*NODE_W-1:0] mem [MAX_EDGES];
  logic [2*NODE_W-1:0] rd_data_r;
  logic [FILL_W-1:0]   fill_r;
  logic                drop_r;
  logic                bad;
  logic                wr_en;

  // An edge is refused when an endpoint is out of range or the store is full.
  assign bad = (cmd.from_num == '0) || (cmd.to_num == '0) || (cmd.from_num > cmd.n) ||
               (cmd.to_num > cmd.n) || (fill_r == FILL_W'(MAX_EDGES));
  assign wr_en = cmd.append && !bad;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[EADDR_W-1:0]] <= {NODE_W'(cmd.from_num - 1'b1), NODE_W'(cmd.to_num - 1'b1)};
    end
    rd_data_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      fill_r <= '0;
      drop_r <= 1'b0;
    end else if (cmd.append) begin
      if (bad) begin
        drop_r <= 1'b1;
      end else begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign stat.fill   = fill_r;
  assign stat.drop   = drop_r;
  assign stat.rd_src = rd_data_r[2*NODE_W-1:NODE_W];
  assign stat.rd_tgt = rd_data_r[NODE_W-1:0];

endmodule

[hw/rtl/scc_engine.sv]
// ----------------------------------------------------------------------------
// scc_engine
// Sequencer for both depth-first passes and the result stream.
// ----------------------------------------------------------------------------
module scc_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [scc_pkg::CNT_W-1:0] n_i,
  scc_in_if.sink                    in_ch,
  scc_out_if.source                 out_ch,
  output scc_pkg::es_cmd_t          es_cmd,
  input  scc_pkg::es_stat_t         es_stat
);
  import scc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S1_ROOT, S1_RD, S1_EV, S1_POP,
    S2_NEXT, S2_FO, S2_RD, S2_EV, S2_POP,
    S_OUT_RD, S_OUT_WAIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    root_r, root_nxt;
  logic [NODE_W-1:0]   top_r, top_nxt;
  logic [FILL_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;
  logic [CNT_W-1:0]    comps_r, comps_nxt;
  logic [CNT_W-1:0]    oidx_r, oidx_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] labelled_r, labelled_nxt;

  // Walk stack: node and saved edge cursor of each frame below the top.
  logic [NODE_W+FILL_W-1:0] stk_mem [MAX_NODES];
  logic [NODE_W+FILL_W-1:0] stk_rdata_r, stk_wdata;
  logic                     stk_we;
  logic [NODE_W-1:0]        stk_waddr, stk_raddr;

  logic [NODE_W-1:0] fo_mem [MAX_NODES];
  logic [NODE_W-1:0] fo_rdata_r;
  logic              fo_we;

  logic [CNT_W-1:0]  lbl_mem [MAX_NODES];
  logic [CNT_W-1:0]  lbl_rdata_r, lbl_wdata;
  logic              lbl_we;
  logic [NODE_W-1:0] lbl_waddr;

  logic [CNT_W-1:0]  depth_m1;
  logic              edge_hit1, edge_hit2, out_fire, out_last;
  logic              es_clear;

  assign depth_m1  = depth_r - 1'b1;
  assign stk_raddr = depth_m1[NODE_W-1:0];
  assign edge_hit1 = (es_stat.rd_src == top_r) && ({1'b0, es_stat.rd_tgt} < n_i);
  assign edge_hit2 = (es_stat.rd_tgt == top_r) && ({1'b0, es_stat.rd_src} < n_i) &&
                     !labelled_r[es_stat.rd_src];
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign out_last  = (oidx_r + 1'b1) == n_i;

  always_comb begin
    state_nxt    = state_r;
    root_nxt     = root_r;
    top_nxt      = top_r;
    cur_nxt      = cur_r;
    depth_nxt    = depth_r;
    done_nxt     = done_r;
    comps_nxt    = comps_r;
    oidx_nxt     = oidx_r;
    visited_nxt  = visited_r;
    labelled_nxt = labelled_r;
    stk_we       = 1'b0;
    stk_waddr    = depth_r[NODE_W-1:0];
    stk_wdata    = {top_r, cur_r + 1'b1};
    fo_we        = 1'b0;
    lbl_we       = 1'b0;
    lbl_waddr    = es_stat.rd_src;
    lbl_wdata    = comps_r;
    es_clear     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.req_type == REQ_FINISH) begin
          root_nxt  = '0;
          done_nxt  = '0;
          state_nxt = S1_ROOT;
        end
      end
      S1_ROOT: begin
        if (root_r == n_i) begin
          comps_nxt = '0;
          state_nxt = S2_NEXT;
        end else if (visited_r[root_r[NODE_W-1:0]]) begin
          root_nxt = root_r + 1'b1;
        end else begin
          visited_nxt[root_r[NODE_W-1:0]] = 1'b1;
          top_nxt   = root_r[NODE_W-1:0];
          cur_nxt   = '0;
          depth_nxt = '0;
          state_nxt = S1_RD;
        end
      end
      S1_RD: begin
        if (cur_r == es_stat.fill) begin
          // Node finished: record it and return to the frame below, or to the next root at depth zero.
          fo_we    = 1'b1;
          done_nxt = done_r + 1'b1;
          if (depth_r == '0) begin
            root_nxt  = root_r + 1'b1;
            state_nxt = S1_ROOT;
          end else begin
            state_nxt = S1_POP;
          end
        end else begin
          state_nxt = S1_EV;
        end
      end
      S1_EV: begin
        cur_nxt   = cur_r + 1'b1;
        state_nxt = S1_RD;
        if (edge_hit1 && !visited_r[es_stat.rd_tgt]) begin
          visited_nxt[es_stat.rd_tgt] = 1'b1;
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
          top_nxt   = es_stat.rd_tgt;
          cur_nxt   = '0;
        end
      end
      S1_POP: begin
        top_nxt   = stk_rdata_r[NODE_W+FILL_W-1:FILL_W];
        cur_nxt   = stk_rdata_r[FILL_W-1:0];
        depth_nxt = depth_m1;
        state_nxt = S1_RD;
      end
      S2_NEXT: begin
        if (done_r == '0) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S2_FO;
        end
      end
      S2_FO: begin
        done_nxt  = done_r - 1'b1;
        state_nxt = S2_NEXT;
        if (!labelled_r[fo_rdata_r]) begin
          comps_nxt = comps_r + 1'b1;
          labelled_nxt[fo_rdata_r] = 1'b1;
          lbl_we    = 1'b1;
          lbl_waddr = fo_rdata_r;
          lbl_wdata = comps_r + 1'b1;
          top_nxt   = fo_rdata_r;
          cur_nxt   = '0;
          depth_nxt = '0;
          state_nxt = S2_RD;
        end
      end
      S2_RD: begin
        if (cur_r == es_stat.fill) begin
          state_nxt = (depth_r == '0) ? S2_NEXT : S2_POP;
        end else begin
          state_nxt = S2_EV;
        end
      end
      S2_EV: begin
        cur_nxt   = cur_r + 1'b1;
        state_nxt = S2_RD;
        if (edge_hit2) begin
          labelled_nxt[es_stat.rd_src] = 1'b1;
          lbl_we    = 1'b1;
          stk_we    = 1'b1;
          stk_wdata = {es_stat.rd_src, FILL_W'(0)};
          depth_nxt = depth_r + 1'b1;
        end
      end
      S2_POP: begin
        top_nxt   = stk_rdata_r[NODE_W+FILL_W-1:FILL_W];
        cur_nxt   = '0;
        depth_nxt = depth_m1;
        state_nxt = S2_RD;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_fire) begin
          if (out_last) begin
            visited_nxt  = '0;
            labelled_nxt = '0;
            es_clear     = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            oidx_nxt  = oidx_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      visited_r  <= '0;
      labelled_r <= '0;
      depth_r    <= '0;
      done_r     <= '0;
      comps_r    <= '0;
      oidx_r     <= '0;
      root_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      visited_r  <= visited_nxt;
      labelled_r <= labelled_nxt;
      depth_r    <= depth_nxt;
      done_r     <= done_nxt;
      comps_r    <= comps_nxt;
      oidx_r     <= oidx_nxt;
      root_r     <= root_nxt;
    end
    top_r <= top_nxt;
    cur_r <= cur_nxt;
  end

  function automatic logic [NODE_W-1:0] done_m1_addr();
    logic [CNT_W-1:0] d;
    d = done_r - 1'b1;
    return d[NODE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
    if (fo_we) begin
      fo_mem[done_r[NODE_W-1:0]] <= top_r;
    end
    fo_rdata_r <= fo_mem[done_m1_addr()];
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    if (state_r == S_OUT_RD) begin
      lbl_rdata_r <= lbl_mem[oidx_r[NODE_W-1:0]];
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign es_cmd.append    = in_ch.valid && in_ch.ready && (in_ch.req_type == REQ_EDGE);
  assign es_cmd.clear     = es_clear;
  assign es_cmd.from_num  = in_ch.edge_from;
  assign es_cmd.to_num    = in_ch.edge_to;
  assign es_cmd.n         = n_i;
  assign es_cmd.rd_addr   = cur_r[EADDR_W-1:0];

  assign out_ch.valid           = (state_r == S_OUT_WAIT);
  assign out_ch.node_number     = oidx_r + 1'b1;
  assign out_ch.component_label = lbl_rdata_r;
  assign out_ch.component_total = comps_r;
  assign out_ch.dropped_edges   = es_stat.drop;
  assign out_ch.last_node       = out_last;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_NODES))
    else $error("walk stack depth above node capacity");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (oidx_r < n_i))
    else $error("result for a node beyond the node count");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |=> (state_r == S_IDLE && visited_r == '0 && labelled_r == '0))
    else $error("graph not cleared after the final result");
`endif

endmodule

[hw/rtl/strongly_connected_components_top.sv]
// Edge transaction: taken one per cycle while idle; no result.
// Finish transaction: both passes run, and every node scans the whole edge memory
// once, each edge examination costing a registered read and a compare; then one
// result per node is read and held valid until the sink takes it. Synchronous
// active-low reset empties the edge store and sets node_count to 64.
// ----------------------------------------------------------------------------
// strongly_connected_components_top
// Kosaraju component labelling over a stored directed graph.
// ----------------------------------------------------------------------------
module strongly_connected_components_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [scc_pkg::CNT_W-1:0] cfg_wdata,
  scc_in_if.sink                    in_ch,
  scc_out_if.source                 out_ch
);
  import scc_pkg::*;

  logic [CNT_W-1:0] node_count_r;
  logic [CNT_W-1:0] n_eff;
  es_cmd_t          es_cmd;
  es_stat_t         es_stat;

  // The user must write the node count register only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(MAX_NODES);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // A count of zero behaves as one node and anything above capacity as full size.
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  // The edge store holds source and target per transaction in arrival order.
  scc_edge_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (es_cmd),
    .stat (es_stat)
  );

  // The engine runs both depth-first passes from the edge store, then streams
  // one result per node and clears the graph after the last one is taken.
  scc_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .n_i    (n_eff),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .es_cmd (es_cmd),
    .es_stat(es_stat)
  );

endmodule
